// File: rtl/core/vnt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnt_pkg
// shared types and command codes of the trilinear value noise core
// ----------------------------------------------------------------------------
package vnt_pkg;

    localparam int CMD_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 3'd0,
        CMD_LOAD_VAL = 3'd1,
        CMD_LOAD_XP = 3'd2,
        CMD_LOAD_YP = 3'd3,
        CMD_LOAD_ZP = 3'd4
    } cmd_t;

    localparam int PERM_W = 8;
    localparam int IN_VALUE_W = 16;
    localparam int COORD_W = 32;
    localparam int OUT_W = 16;

    // table write request decoded in the back part
    typedef struct packed {
        logic val_we;
        logic xp_we;
        logic yp_we;
        logic zp_we;
    } tbl_we_t;

    // one queued request, loads and samples alike
    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [PERM_W-1:0]     index;
        logic [IN_VALUE_W-1:0] value;
        logic [3*COORD_W-1:0]  coord;
    } q_ent_t;

endpackage

// File: rtl/core/vnt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module vnt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: rtl/core/vnt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnt_front
// accepts requests and queues them in order for the back part
// ----------------------------------------------------------------------------
module vnt_front
    import vnt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      in_cmd,
    input  logic [PERM_W-1:0]     in_index,
    input  logic [IN_VALUE_W-1:0] in_value,
    input  logic [COORD_W-1:0]    in_x,
    input  logic [COORD_W-1:0]    in_y,
    input  logic [COORD_W-1:0]    in_z,
    output logic                  q_valid,
    input  logic                  q_ready,
    output q_ent_t                q_ent
);
    // two-entry queue, loads ride along so they stay ordered with samples
    q_ent_t q0_reg, q1_reg;
    q_ent_t in_ent;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop, acc;

    assign in_ready = (cnt_reg != 2'd2);
    assign acc = in_valid && in_ready;
    assign push = acc;
    assign pop = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_ent = q0_reg;

    assign in_ent.cmd = in_cmd;
    assign in_ent.index = in_index;
    assign in_ent.value = in_value;
    assign in_ent.coord = {in_z, in_y, in_x};

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (!push && pop) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            q0_reg <= q1_reg;
        end
        if (push) begin
            if (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)) q0_reg <= in_ent;
            else q1_reg <= in_ent;
        end
    end
endmodule

// File: rtl/core/vnt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnt_back
// table loads and sample pipeline: permutation reads, value reads, blend
// ----------------------------------------------------------------------------
module vnt_back
    import vnt_pkg::*;
#(
    parameter int IDX_W = 8,
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  q_ent_t                q_ent,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_W-1:0]      m_data
);
    localparam int W_W = FRAC_BITS + 1;
    localparam int NST = 7;
    localparam int SUM_W = VALUE_BITS + 4;

    // stall-everything pipeline with output register
    logic [NST-1:0] v_reg;
    logic adv;
    assign adv = !v_reg[NST-1] || m_ready;
    assign q_ready = adv;
    assign m_valid = v_reg[NST-1];

    // decode of the request entering the pipeline
    tbl_we_t we0;
    logic is_smp;
    always_comb begin
        we0 = '0;
        is_smp = 1'b0;
        if (q_valid) begin
            case (q_ent.cmd)
                CMD_SAMPLE:   is_smp = 1'b1;
                CMD_LOAD_VAL: we0.val_we = 1'b1;
                CMD_LOAD_XP:  we0.xp_we = 1'b1;
                CMD_LOAD_YP:  we0.yp_we = 1'b1;
                CMD_LOAD_ZP:  we0.zp_we = 1'b1;
                default:      we0 = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NST-2:0], is_smp};
        end
    end

    // load address and data
    logic [IDX_W+PERM_W-1:0] widx_ext;
    logic [IDX_W-1:0] waddr0;
    logic [VALUE_BITS+IN_VALUE_W-1:0] val_ext;
    logic [PERM_W-1:0] wperm0;
    assign widx_ext = {{IDX_W{1'b0}}, q_ent.index};
    assign waddr0 = widx_ext[IDX_W-1:0];
    assign val_ext = {{VALUE_BITS{1'b0}}, q_ent.value};
    assign wperm0 = q_ent.value[PERM_W-1:0];

    // value loads are written one stage later, where the value tables are read
    logic val_we_reg;
    logic [IDX_W-1:0] vwaddr_reg;
    logic [VALUE_BITS-1:0] vwval_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_we_reg <= 1'b0;
        end else if (adv) begin
            val_we_reg <= we0.val_we;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            vwaddr_reg <= waddr0;
            vwval_reg <= val_ext[VALUE_BITS-1:0];
        end
    end

    // stage 0: split coordinates
    logic [2*COORD_W-1:0] crd_ext [3];
    logic [IDX_W-1:0] c_lo [3];
    logic [IDX_W-1:0] c_hi [3];
    logic [FRAC_BITS-1:0] f0 [3];
    logic [FRAC_BITS-1:0] f1_reg [3];
    logic [FRAC_BITS-1:0] f2_reg [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            crd_ext[a] = {{COORD_W{q_ent.coord[a*COORD_W+COORD_W-1]}},
                          q_ent.coord[a*COORD_W +: COORD_W]};
            c_lo[a] = crd_ext[a][FRAC_BITS +: IDX_W];
            c_hi[a] = c_lo[a] + IDX_W'(1);
            f0[a] = crd_ext[a][FRAC_BITS-1:0];
        end
    end

    // permutation reads, one lo and one hi copy per axis, registered read
    logic [PERM_W-1:0] p_lo [3];
    logic [PERM_W-1:0] p_hi [3];
    logic [2:0] pwe;
    assign pwe = {we0.zp_we, we0.yp_we, we0.xp_we} & {3{adv}};
    for (genvar a = 0; a < 3; a++) begin : g_perm
        vnt_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_lo (
            .aclk(aclk), .we(pwe[a]), .waddr(waddr0), .wdata(wperm0),
            .re(adv), .raddr(c_lo[a]), .rdata(p_lo[a]));
        vnt_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_hi (
            .aclk(aclk), .we(pwe[a]), .waddr(waddr0), .wdata(wperm0),
            .re(adv), .raddr(c_hi[a]), .rdata(p_hi[a]));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_reg <= f0;
            f2_reg <= f1_reg;
        end
    end

    // stage 1: value addresses, eight value table copies
    logic [IDX_W+PERM_W-1:0] plo_ext [3];
    logic [IDX_W+PERM_W-1:0] phi_ext [3];
    logic [IDX_W-1:0] vaddr [8];
    logic [VALUE_BITS-1:0] val [8];
    logic [VALUE_BITS-1:0] val_reg [8];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            plo_ext[a] = {{IDX_W{1'b0}}, p_lo[a]};
            phi_ext[a] = {{IDX_W{1'b0}}, p_hi[a]};
        end
        for (int n = 0; n < 8; n++) begin
            vaddr[n] = (n[2] ? phi_ext[0][IDX_W-1:0] : plo_ext[0][IDX_W-1:0])
                     ^ (n[1] ? phi_ext[1][IDX_W-1:0] : plo_ext[1][IDX_W-1:0])
                     ^ (n[0] ? phi_ext[2][IDX_W-1:0] : plo_ext[2][IDX_W-1:0]);
        end
    end
    logic vwe;
    assign vwe = val_we_reg && adv;
    for (genvar n = 0; n < 8; n++) begin : g_val
        vnt_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_SIZE)) u_val (
            .aclk(aclk), .we(vwe), .waddr(vwaddr_reg), .wdata(vwval_reg),
            .re(adv), .raddr(vaddr[n]), .rdata(val[n]));
    end

    // weights computed alongside: stage 2 wxy, stage 3 corner weight
    logic [W_W-1:0] wx [2], wy [2], wz [2];
    always_comb begin
        wx[1] = {1'b0, f2_reg[0]};
        wy[1] = {1'b0, f2_reg[1]};
        wz[1] = {1'b0, f2_reg[2]};
        wx[0] = {1'b1, {FRAC_BITS{1'b0}}} - wx[1];
        wy[0] = {1'b1, {FRAC_BITS{1'b0}}} - wy[1];
        wz[0] = {1'b1, {FRAC_BITS{1'b0}}} - wz[1];
    end

    logic [2*W_W-1:0] pxy [4];
    logic [W_W-1:0] wxy_reg [4];
    logic [W_W-1:0] wz_reg [2];
    logic [VALUE_BITS-1:0] val3_reg [8];
    logic [2*W_W-1:0] pw [8];
    logic [W_W-1:0] w_reg [8];
    logic [W_W+VALUE_BITS-1:0] pt [8];
    logic [VALUE_BITS-1:0] t_reg [8];
    logic [SUM_W-1:0] s_reg [2];
    logic [SUM_W-1:0] tot;

    always_comb begin
        for (int n = 0; n < 4; n++) pxy[n] = wx[n/2] * wy[n%2];
        for (int n = 0; n < 8; n++) pw[n] = wxy_reg[n/2] * wz_reg[n%2];
        for (int n = 0; n < 8; n++) pt[n] = w_reg[n] * val3_reg[n];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            val_reg <= val;
            for (int n = 0; n < 4; n++) wxy_reg[n] <= pxy[n][FRAC_BITS +: W_W];
            wz_reg <= wz;
            val3_reg <= val_reg;
            for (int n = 0; n < 8; n++) w_reg[n] <= pw[n][FRAC_BITS +: W_W];
            for (int n = 0; n < 8; n++) t_reg[n] <= pt[n][FRAC_BITS +: VALUE_BITS];
            s_reg[0] <= SUM_W'(t_reg[0]) + SUM_W'(t_reg[1]) + SUM_W'(t_reg[2])
                      + SUM_W'(t_reg[3]);
            s_reg[1] <= SUM_W'(t_reg[4]) + SUM_W'(t_reg[5]) + SUM_W'(t_reg[6])
                      + SUM_W'(t_reg[7]);
        end
    end

    // stage 6 output register
    logic [OUT_W+SUM_W-1:0] tot_ext;
    logic [OUT_W-1:0] out_reg;
    assign tot = s_reg[0] + s_reg[1];
    assign tot_ext = {{OUT_W{1'b0}}, tot};
    always_ff @(posedge aclk) begin
        if (adv) out_reg <= tot_ext[OUT_W-1:0];
    end
    assign m_data = out_reg;
endmodule

// File: rtl/core/value_noise_trilinear_3d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_trilinear_3d_core
// 3d value noise with trilinear blending over loadable lattice tables
// ----------------------------------------------------------------------------
// a sample result is registered in turn at the permutation rams, value rams, val_reg, val3_reg, t_reg, s_reg, out_reg
// throughput: one request per cycle while the output is not stalled, loads and samples mixed freely
// the rate is set by replicated table rams: 6 permutation copies, 8 value copies
// reset: aresetn clears queue and pipeline valid bits; tables keep contents
// tables are undefined until loaded
module value_noise_trilinear_3d_core
    import vnt_pkg::*;
#(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: table_index[7:0], table_value[23:8], coord_x[55:24],
    //        coord_y[87:56], coord_z[119:88]
    input  logic [119:0] s_tdata,
    // tuser: command[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: noise_value[15:0]
    output logic [15:0]  m_tdata
);
    localparam int IDX_W = $clog2(TABLE_SIZE);

    logic                  q_valid, q_ready;
    q_ent_t                q_ent;

    // front: accept and queue every request in order
    vnt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tuser), .in_index(s_tdata[7:0]), .in_value(s_tdata[23:8]),
        .in_x(s_tdata[55:24]), .in_y(s_tdata[87:56]), .in_z(s_tdata[119:88]),
        .q_valid(q_valid), .q_ready(q_ready), .q_ent(q_ent));

    // back: table loads in request order and the sample pipeline
    vnt_back #(.IDX_W(IDX_W), .TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS),
               .VALUE_BITS(VALUE_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_ent(q_ent),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_tdata));
endmodule
